[sv/assert_macros.svh]
// Assertion helpers included by the qualifier unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk, disabled while in reset.
`define TFQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be true at a rising edge of clk outside reset.
`define TFQ_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[sv/tfq_pkg.sv]
package tfq_pkg;

    // One thermocouple sample.
    typedef struct packed {
        logic signed [15:0] temperature;
        logic               reading_invalid;
        logic        [7:0]  sensor_status;
    } tfq_in_t;

    // One qualified result.
    typedef struct packed {
        logic signed [15:0] trusted_temperature;
        logic               fault;
        logic        [7:0]  status_echo;
    } tfq_out_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SENSOR_PRESENT     = 3'd0,
        REG_CIRCUIT_SUSTAIN    = 3'd1,
        REG_INVALID_DEBOUNCE   = 3'd2,
        REG_GOOD_STREAK        = 3'd3,
        REG_HOT_THRESHOLD      = 3'd4,
        REG_LOW_LIMIT          = 3'd5,
        REG_HIGH_LIMIT         = 3'd6,
        REG_CIRCUIT_FAULT_MASK = 3'd7
    } tfq_reg_t;

    // Register reset values.
    localparam logic               RST_SENSOR_PRESENT     = 1'b1;
    localparam logic        [7:0]  RST_CIRCUIT_SUSTAIN    = 8'd15;
    localparam logic        [7:0]  RST_INVALID_DEBOUNCE   = 8'd3;
    localparam logic        [7:0]  RST_GOOD_STREAK        = 8'd10;
    localparam logic signed [15:0] RST_HOT_THRESHOLD      = 16'sd1600;
    localparam logic signed [15:0] RST_LOW_LIMIT          = -16'sd640;
    localparam logic signed [15:0] RST_HIGH_LIMIT         = 16'sd17600;
    localparam logic        [7:0]  RST_CIRCUIT_FAULT_MASK = 8'd48;

    // Status byte reported when no sensor is fitted.
    localparam logic [7:0] STATUS_ABSENT = 8'hFF;
    // Saturation point of the run counters.
    localparam logic [7:0] RUN_MAX       = 8'hFF;

endpackage

[sv/thermocouple_fault_qualifier_unit.sv]
// Thermocouple fault qualifier. Each sample transfer is registered, then
// checked against the plausibility window, the invalid flag and the circuit
// status bits while it is held in stage one. When it moves on, the bad and
// good run counters, the fault flag and the last trusted temperature are
// updated and the result is loaded into the output register; a stalled
// output holds the sample in stage one. One sample is accepted every cycle
// as long as the output side keeps taking results; the single output
// register sets that figure. Configuration registers are written through
// the plain write port and should only change while no sample is in
// flight. After reset the channel reports a fault until enough clean
// samples have been seen.
`include "assert_macros.svh"

module thermocouple_fault_qualifier_unit
    import tfq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Sample input channel.
    input  logic                   in_valid,
    output logic                   in_stall,
    input  tfq_in_t                in_data,
    // Result output channel.
    output logic                   out_valid,
    input  logic                   out_stall,
    output tfq_out_t               out_data,
    // Configuration write port.
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers.
    logic               sensor_present_reg;
    logic        [7:0]  circuit_sustain_reg;
    logic        [7:0]  invalid_debounce_reg;
    logic        [7:0]  good_streak_reg;
    logic signed [15:0] hot_threshold_reg;
    logic signed [15:0] low_limit_reg;
    logic signed [15:0] high_limit_reg;
    logic        [7:0]  circuit_fault_mask_reg;

    // Pipeline registers.
    logic     s1_valid_reg;
    tfq_in_t  s1_data_reg;
    logic     out_valid_reg;
    tfq_out_t out_data_reg;

    // Qualifier state.
    logic        [7:0]  bad_run_reg;
    logic        [7:0]  bad_run_next;
    logic        [7:0]  good_run_reg;
    logic        [7:0]  good_run_next;
    logic               fault_reg;
    logic               fault_next;
    logic signed [15:0] held_temp_reg;
    logic signed [15:0] held_temp_next;
    logic        [7:0]  echo_next;

    // Handshake control.
    logic out_free;
    logic s1_advance;
    logic in_transfer;

    // Classification of the sample in stage one.
    logic       in_window;
    logic       invalid;
    logic       circuit;
    logic       suspect;
    logic [7:0] run_limit;
    logic [7:0] bad_run_inc;
    logic [7:0] good_run_inc;

    assign out_free    = !out_valid_reg || !out_stall;
    assign s1_advance  = s1_valid_reg && out_free;
    assign in_stall    = s1_valid_reg && !out_free;
    assign in_transfer = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_present_reg     <= RST_SENSOR_PRESENT;
            circuit_sustain_reg    <= RST_CIRCUIT_SUSTAIN;
            invalid_debounce_reg   <= RST_INVALID_DEBOUNCE;
            good_streak_reg        <= RST_GOOD_STREAK;
            hot_threshold_reg      <= RST_HOT_THRESHOLD;
            low_limit_reg          <= RST_LOW_LIMIT;
            high_limit_reg         <= RST_HIGH_LIMIT;
            circuit_fault_mask_reg <= RST_CIRCUIT_FAULT_MASK;
        end
        else if (cfg_write_en)
        begin
            unique case (tfq_reg_t'(cfg_index))
                REG_SENSOR_PRESENT:     sensor_present_reg     <= cfg_data[0];
                REG_CIRCUIT_SUSTAIN:    circuit_sustain_reg    <= cfg_data[7:0];
                REG_INVALID_DEBOUNCE:   invalid_debounce_reg   <= cfg_data[7:0];
                REG_GOOD_STREAK:        good_streak_reg        <= cfg_data[7:0];
                REG_HOT_THRESHOLD:      hot_threshold_reg      <= cfg_data;
                REG_LOW_LIMIT:          low_limit_reg          <= cfg_data;
                REG_HIGH_LIMIT:         high_limit_reg         <= cfg_data;
                REG_CIRCUIT_FAULT_MASK: circuit_fault_mask_reg <= cfg_data[7:0];
                default:                sensor_present_reg     <= sensor_present_reg;
            endcase
        end
    end

    // Input register: takes a sample whenever stage one is free or draining.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            s1_data_reg <= in_data;
        end
    end

    // Sample classification.
    always_comb
    begin
        in_window = (s1_data_reg.temperature > low_limit_reg)
                 && (s1_data_reg.temperature < high_limit_reg);
        invalid   = s1_data_reg.reading_invalid || !in_window;
        circuit   = (s1_data_reg.sensor_status & circuit_fault_mask_reg) != 8'd0;
        suspect   = invalid
                 || (circuit && (s1_data_reg.temperature < hot_threshold_reg));
        run_limit    = invalid ? invalid_debounce_reg : circuit_sustain_reg;
        bad_run_inc  = (bad_run_reg == RUN_MAX) ? RUN_MAX : bad_run_reg + 8'd1;
        good_run_inc = (good_run_reg == RUN_MAX) ? RUN_MAX : good_run_reg + 8'd1;
    end

    // Run counters, fault flag and held temperature.
    always_comb
    begin
        bad_run_next   = bad_run_reg;
        good_run_next  = good_run_reg;
        fault_next     = fault_reg;
        held_temp_next = held_temp_reg;
        echo_next      = s1_data_reg.sensor_status;
        if (!sensor_present_reg)
        begin
            fault_next = 1'b1;
            echo_next  = STATUS_ABSENT;
        end
        else if (!suspect)
        begin
            bad_run_next  = 8'd0;
            good_run_next = good_run_inc;
            if (!(fault_reg && (good_run_inc < good_streak_reg)))
            begin
                fault_next     = 1'b0;
                held_temp_next = s1_data_reg.temperature;
            end
        end
        else
        begin
            good_run_next = 8'd0;
            bad_run_next  = bad_run_inc;
            if (bad_run_inc >= run_limit)
            begin
                fault_next = 1'b1;
            end
        end
    end

    // State update when a sample moves into the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_run_reg   <= 8'd0;
            good_run_reg  <= 8'd0;
            fault_reg     <= 1'b1;
            held_temp_reg <= 16'sd0;
        end
        else if (s1_advance)
        begin
            bad_run_reg   <= bad_run_next;
            good_run_reg  <= good_run_next;
            fault_reg     <= fault_next;
            held_temp_reg <= held_temp_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_data_reg.trusted_temperature <= held_temp_next;
            out_data_reg.fault               <= fault_next;
            out_data_reg.status_echo         <= echo_next;
        end
    end

    // An absent sensor always yields a faulted result with the absent status.
    `TFQ_ASSERT(a_absent_result,
        (s1_advance && !sensor_present_reg) |=>
        (out_valid_reg && out_data_reg.fault && out_data_reg.status_echo == STATUS_ABSENT),
        "absent sensor did not report a fault")

    // The two run counters are never both running.
    `TFQ_ASSERT_NEVER(a_runs_exclusive,
        (bad_run_reg != 8'd0) && (good_run_reg != 8'd0),
        "bad and good runs both nonzero")

    // A fault only clears on a clean sample, so the good run has started.
    `TFQ_ASSERT(a_fault_clear_on_good,
        $fell(fault_reg) |-> (good_run_reg != 8'd0),
        "fault cleared without a clean sample")

    // The input side only stalls while stage one holds a sample.
    `TFQ_ASSERT(a_stall_has_cause,
        in_stall |-> (s1_valid_reg && out_valid_reg),
        "input stalled with room in the pipeline")

endmodule
